/* rtl/srsd_pkg.sv */
// ----------------------------------------------------------------------------
// srsd_pkg: shared types and constants of the SYN ratio scan detector
// Field widths, status codes, ethertypes and the front-to-back command word.
// ----------------------------------------------------------------------------
package srsd_pkg;

	localparam int TableDepth = 1024;
	localparam int IdxW       = $clog2(TableDepth);
	localparam int UsedW      = IdxW + 1;
	localparam int CountW     = 32;
	localparam int QDepth     = 4;
	localparam int QPtrW      = $clog2(QDepth);

	localparam logic [15:0] EtIpv4 = 16'h0800;
	localparam logic [15:0] EtArp  = 16'h0806;
	localparam logic [15:0] EtRarp = 16'h8035;
	localparam logic [15:0] EtPup  = 16'h0200;
	localparam logic [15:0] MinIpLen  = 16'd34;
	localparam logic [15:0] MinTcpLen = 16'd54;
	localparam logic [7:0]  FlSyn    = 8'h02;
	localparam logic [7:0]  FlSynAck = 8'h12;
	localparam logic [15:0] ThreshReset = 16'd3;

	typedef enum logic [3:0] {
		ST_MATCHED   = 4'd0,
		ST_NEW       = 4'd1,
		ST_IGNORED   = 4'd2,
		ST_FULL      = 4'd3,
		ST_SHORT_IP  = 4'd4,
		ST_SHORT_TCP = 4'd5,
		ST_ARP       = 4'd6,
		ST_RARP      = 4'd7,
		ST_PUP       = 4'd8,
		ST_OTHER     = 4'd9,
		ST_REPORT    = 4'd10,
		ST_BAD_INDEX = 4'd11
	} status_t;

	typedef enum logic [1:0] {
		CMD_DONE  = 2'd0,
		CMD_PKT   = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_kind_t;

	// word passed from the classifier to the table engine
	typedef struct packed {
		cmd_kind_t   kind;
		status_t     status;
		logic [31:0] src;
		logic [31:0] dst;
		logic [7:0]  flags;
		logic [9:0]  qidx;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [9:0]  entry_index;
		logic [31:0] first_addr;
		logic [31:0] second_addr;
		logic [31:0] connect_requests;
		logic [31:0] success_responses;
		logic [31:0] ratio;
		logic        scan_alert;
	} result_t;

endpackage

/* rtl/srsd_if.sv */
// ----------------------------------------------------------------------------
// srsd_in_if / srsd_out_if / srsd_cfg_if: handshake channels
// Valid/ready channels carrying the input word, the result word and config.
// ----------------------------------------------------------------------------
interface srsd_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [15:0] frame_type;
	logic [15:0] frame_length;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	logic [7:0]  tcp_flags;
	logic [9:0]  query_index;
	modport source (output valid, opcode, frame_type, frame_length, src_addr, dst_addr,
		tcp_flags, query_index, input ready);
	modport sink (input valid, opcode, frame_type, frame_length, src_addr, dst_addr,
		tcp_flags, query_index, output ready);
endinterface

interface srsd_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [9:0]  entry_index;
	logic [31:0] first_addr;
	logic [31:0] second_addr;
	logic [31:0] connect_requests;
	logic [31:0] success_responses;
	logic [31:0] ratio;
	logic        scan_alert;
	modport source (output valid, status, entry_index, first_addr, second_addr,
		connect_requests, success_responses, ratio, scan_alert, input ready);
	modport sink (input valid, status, entry_index, first_addr, second_addr,
		connect_requests, success_responses, ratio, scan_alert, output ready);
endinterface

interface srsd_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* rtl/syn_ratio_scan_detector_top.sv */
// ----------------------------------------------------------------------------
// syn_ratio_scan_detector_top: SYN / SYN-ACK ratio scan detector
// Tracks address pairs and reports request-to-success ratios on query.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one word per packet or query, taken when valid and ready are high.
//   out_ch : exactly one result word per input word, in order.
//   cfg_ch : writes ratio_threshold (reset 3); write only while idle.
// A classifier takes words into a four-entry command queue; the table engine
// drains it. Non-IPv4 and short frames are answered without a table walk. A
// packet walks the table one entry at a time (read then compare) until it
// matches or passes the last used entry. A query reads its entry, then runs
// the bit-serial divide when the success count is non-zero. The engine takes
// its next command only in the cycle after the result word has been taken,
// so it takes no new word while a result waits.
// At reset the table is empty (entry count cleared) and the queue is empty;
// table memories are not cleared. When the receiver stalls the result waits
// in the output register, the engine stops, and the queue keeps taking words
// until it is full.
// ----------------------------------------------------------------------------
module syn_ratio_scan_detector_top (
	input  logic        clk,
	input  logic        arst_n,
	srsd_in_if.sink     in_ch,
	srsd_out_if.source  out_ch,
	srsd_cfg_if.sink    cfg_ch
);
	import srsd_pkg::*;

	cmd_t        cmd;
	logic        cmd_valid, cmd_ready;
	logic [15:0] thresh_q;

	// threshold register
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thresh_q <= ThreshReset;
		else if (cfg_ch.valid) thresh_q <= cfg_ch.data;
	end

	srsd_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready)
	);

	srsd_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready), .thresh(thresh_q), .out_ch(out_ch)
	);

endmodule

/* rtl/srsd_front.sv */
// ----------------------------------------------------------------------------
// srsd_front: classifier and command queue
// Classifies each word by opcode, ethertype and length, and queues a command.
// ----------------------------------------------------------------------------
module srsd_front (
	input  logic              clk,
	input  logic              arst_n,
	srsd_in_if.sink           in_ch,
	output srsd_pkg::cmd_t    cmd,
	output logic              cmd_valid,
	input  logic              cmd_ready
);
	import srsd_pkg::*;

	cmd_t            q_mem [QDepth];
	logic [QPtrW:0]  wr_q, rd_q;
	logic            full, empty;
	cmd_t            cls;

	assign full  = (wr_q[QPtrW] != rd_q[QPtrW]) && (wr_q[QPtrW-1:0] == rd_q[QPtrW-1:0]);
	assign empty = (wr_q == rd_q);
	assign in_ch.ready = !full;
	assign cmd_valid   = !empty;
	assign cmd         = q_mem[rd_q[QPtrW-1:0]];

	// classification
	always_comb begin
		cls.src    = in_ch.src_addr;
		cls.dst    = in_ch.dst_addr;
		cls.flags  = in_ch.tcp_flags;
		cls.qidx   = in_ch.query_index;
		cls.kind   = CMD_DONE;
		cls.status = ST_OTHER;
		priority if (in_ch.opcode) begin
			cls.kind = CMD_QUERY;
			cls.status = ST_REPORT;
		end else if (in_ch.frame_type == EtArp) begin
			cls.status = ST_ARP;
		end else if (in_ch.frame_type == EtRarp) begin
			cls.status = ST_RARP;
		end else if (in_ch.frame_type == EtPup) begin
			cls.status = ST_PUP;
		end else if (in_ch.frame_type != EtIpv4) begin
			cls.status = ST_OTHER;
		end else if (in_ch.frame_length < MinIpLen) begin
			cls.status = ST_SHORT_IP;
		end else if (in_ch.frame_length < MinTcpLen) begin
			cls.status = ST_SHORT_TCP;
		end else begin
			cls.kind = CMD_PKT;
			cls.status = ST_MATCHED;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (in_ch.valid && !full) q_mem[wr_q[QPtrW-1:0]] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (in_ch.valid && !full) wr_q <= wr_q + 1'b1;
			if (cmd_valid && cmd_ready) rd_q <= rd_q + 1'b1;
		end
	end

endmodule

/* rtl/srsd_div.sv */
// ----------------------------------------------------------------------------
// srsd_div: radix-2 restoring divider
// Unsigned 32-by-32 division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srsd_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	import srsd_pkg::*;

	logic [31:0] rem_q, quo_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;

	assign trial    = {rem_q, quo_q[31]} - {1'b0, dvs_q};
	assign quotient = quo_q;
	assign done     = busy_q && (cnt_q == 6'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd32;
		end else if (busy_q) begin
			if (cnt_q == 6'd0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - 1'b1;
		end
	end

	// shift-subtract step
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q && cnt_q != 6'd0) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

endmodule

/* rtl/srsd_back.sv */
// ----------------------------------------------------------------------------
// srsd_back: table engine
// Searches the address-pair table entry by entry, updates counts, answers
// queries with the ratio, and holds the result in an output register.
// ----------------------------------------------------------------------------
module srsd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  srsd_pkg::cmd_t    cmd,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  logic [15:0]       thresh,
	srsd_out_if.source        out_ch
);
	import srsd_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_RD    = 6'b000010,
		S_CMP   = 6'b000100,
		S_WR    = 6'b001000,
		S_DIV   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	logic [31:0] m_first [TableDepth];
	logic [31:0] m_second [TableDepth];
	logic [31:0] m_req [TableDepth];
	logic [31:0] m_suc [TableDepth];

	state_t        state_q;
	cmd_t          cmd_q;
	logic [UsedW-1:0] used_q, k_q;
	logic [31:0]   rf_q, rs_q, rr_q, rc_q;
	result_t       res_q;
	result_t       res_init;
	logic          ov_q;
	logic          we;
	logic [IdxW-1:0] wa;
	logic [31:0]   wf, ws, wr, wc;
	logic          hit;
	logic          div_start, div_done;
	logic [31:0]   quot;
	logic [31:0]   thr32;

	assign thr32 = {16'd0, thresh};
	assign hit = (rf_q == cmd_q.src && rs_q == cmd_q.dst) ||
		(rs_q == cmd_q.src && rf_q == cmd_q.dst);
	assign cmd_ready = (state_q == S_IDLE) && !ov_q;
	assign out_ch.valid = ov_q;
	assign out_ch.status = res_q.status;
	assign out_ch.entry_index = res_q.entry_index;
	assign out_ch.first_addr = res_q.first_addr;
	assign out_ch.second_addr = res_q.second_addr;
	assign out_ch.connect_requests = res_q.connect_requests;
	assign out_ch.success_responses = res_q.success_responses;
	assign out_ch.ratio = res_q.ratio;
	assign out_ch.scan_alert = res_q.scan_alert;
	assign div_start = (state_q == S_CMP) && (cmd_q.kind == CMD_QUERY) && (rc_q != 32'd0);

	srsd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(rr_q), .divisor(rc_q), .done(div_done), .quotient(quot)
	);

	// table memories
	always_ff @(posedge clk) begin
		if (we) begin
			m_first[wa] <= wf;
			m_second[wa] <= ws;
			m_req[wa] <= wr;
			m_suc[wa] <= wc;
		end
		rf_q <= m_first[k_q[IdxW-1:0]];
		rs_q <= m_second[k_q[IdxW-1:0]];
		rr_q <= m_req[k_q[IdxW-1:0]];
		rc_q <= m_suc[k_q[IdxW-1:0]];
	end

	// result word as loaded when a command is taken
	always_comb begin
		res_init = '0;
		res_init.status = cmd.status;
		if (cmd.kind == CMD_QUERY && {1'b0, cmd.qidx} >= used_q)
			res_init.status = ST_BAD_INDEX;
	end

	// write port selection
	always_comb begin
		we = 1'b0;
		wa = k_q[IdxW-1:0];
		wf = rf_q;
		ws = rs_q;
		wr = rr_q;
		wc = rc_q;
		if (state_q == S_CMP && cmd_q.kind == CMD_PKT && k_q < used_q && hit) begin
			we = 1'b1;
			if ((cmd_q.flags & FlSynAck) == FlSynAck) begin
				if (rc_q != '1) wc = rc_q + 1'b1;
			end else if ((cmd_q.flags & FlSyn) == FlSyn) begin
				if (rr_q != '1) wr = rr_q + 1'b1;
			end
		end else if (state_q == S_CMP && cmd_q.kind == CMD_PKT && k_q >= used_q &&
			(cmd_q.flags == FlSyn || cmd_q.flags == FlSynAck) &&
			used_q != UsedW'(TableDepth)) begin
			we = 1'b1;
			wa = used_q[IdxW-1:0];
			wf = cmd_q.src;
			ws = cmd_q.dst;
			wr = (cmd_q.flags == FlSyn) ? 32'd1 : 32'd0;
			wc = (cmd_q.flags == FlSynAck) ? 32'd1 : 32'd0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			k_q     <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (ov_q && out_ch.ready) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid && !ov_q) begin
						cmd_q <= cmd;
						res_q <= res_init;
						unique case (cmd.kind)
							CMD_PKT: begin
								k_q <= '0;
								state_q <= S_RD;
							end
							CMD_QUERY: begin
								if ({1'b0, cmd.qidx} >= used_q) begin
									ov_q <= 1'b1;
								end else begin
									k_q <= UsedW'(cmd.qidx);
									state_q <= S_RD;
								end
							end
							default: ov_q <= 1'b1;
						endcase
					end
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					if (cmd_q.kind == CMD_QUERY) begin
						res_q.entry_index <= k_q[9:0];
						res_q.first_addr <= rf_q;
						res_q.second_addr <= rs_q;
						res_q.connect_requests <= rr_q;
						res_q.success_responses <= rc_q;
						if (rc_q != 32'd0) begin
							state_q <= S_DIV;
						end else begin
							res_q.ratio <= (rr_q > thr32) ? rr_q : 32'd1;
							res_q.scan_alert <= ((rr_q > thr32) ? rr_q : 32'd1) > thr32;
							state_q <= S_OUT;
						end
					end else if (k_q < used_q) begin
						if (hit) begin
							res_q.status <= ST_MATCHED;
							res_q.entry_index <= k_q[9:0];
							res_q.first_addr <= rf_q;
							res_q.second_addr <= rs_q;
							res_q.connect_requests <= wr;
							res_q.success_responses <= wc;
							state_q <= S_OUT;
						end else begin
							k_q <= k_q + 1'b1;
							state_q <= S_RD;
						end
					end else begin
						if (cmd_q.flags != FlSyn && cmd_q.flags != FlSynAck) begin
							res_q.status <= ST_IGNORED;
						end else if (used_q == UsedW'(TableDepth)) begin
							res_q.status <= ST_FULL;
						end else begin
							res_q.status <= ST_NEW;
							res_q.entry_index <= used_q[9:0];
							res_q.first_addr <= wf;
							res_q.second_addr <= ws;
							res_q.connect_requests <= wr;
							res_q.success_responses <= wc;
							used_q <= used_q + 1'b1;
						end
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					if (div_done) begin
						res_q.ratio <= quot;
						res_q.scan_alert <= quot > thr32;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					ov_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_WR: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/srsd_checker.sv */
// ----------------------------------------------------------------------------
// srsd_checker: port-level properties of the scan detector
// Watches the channels of the top level over time.
// ----------------------------------------------------------------------------
module srsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  status,
	input logic [31:0] ratio,
	input logic        scan_alert,
	input logic [31:0] first_addr
);
	import srsd_pkg::*;

	// a held result does not change
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(status) && $stable(ratio))
		else $error("result changed while stalled");

	// only reports carry an alert
	a_alert: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scan_alert |-> status == ST_REPORT)
		else $error("alert on non-report");

	// non-entry statuses carry zero fields
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_IGNORED || status == ST_FULL || status == ST_BAD_INDEX ||
		status == ST_OTHER || status == ST_ARP) |-> first_addr == 32'd0 && ratio == 32'd0)
		else $error("non-zero fields on drop");

	// status code in range
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_BAD_INDEX)
		else $error("status out of range");

endmodule

bind syn_ratio_scan_detector_top srsd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.status(out_ch.status), .ratio(out_ch.ratio), .scan_alert(out_ch.scan_alert),
	.first_addr(out_ch.first_addr)
);

/* verif/syn_ratio_scan_detector_top_tb.sv */
// ----------------------------------------------------------------------------
// syn_ratio_scan_detector_top_tb: self-checking bench for the scan detector
// Drives packet and query words with random idling on both channels. It
// predicts every result word from its own copy of the pair table and checks
// the words in order. Coverage comes from directed cases, threshold sweeps
// and random traffic over a small pool of address pairs; the final sweep
// runs with no idling.
// ----------------------------------------------------------------------------
module syn_ratio_scan_detector_top_tb;
	import srsd_pkg::*;

	localparam int CycleLimit = 8000000;
	localparam int DrainWait  = 64;
	localparam int PoolSize   = 24;

	typedef struct {
		logic        opcode;
		logic [15:0] frame_type;
		logic [15:0] frame_length;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [7:0]  tcp_flags;
		logic [9:0]  query_index;
	} pkt_word_t;

	logic clk;
	logic arst_n;

	srsd_in_if  in_ch();
	srsd_out_if out_ch();
	srsd_cfg_if cfg_ch();

	syn_ratio_scan_detector_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// predictor copy of the pair table
	logic [31:0] tbl_first   [TableDepth];
	logic [31:0] tbl_second  [TableDepth];
	logic [31:0] tbl_request [TableDepth];
	logic [31:0] tbl_success [TableDepth];
	int unsigned pairs_used;
	logic [15:0] scan_threshold;

	result_t     pending_results[$];
	int unsigned mismatch_count;
	int unsigned cycle_count;
	bit          src_idle_en;
	bit          snk_idle_en;
	int unsigned snk_stall_left;
	logic [31:0] pool_a [PoolSize];
	logic [31:0] pool_b [PoolSize];

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic [31:0] sat_inc(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// expected result word for one accepted input word; updates the table
	function automatic result_t predict_result(pkt_word_t w);
		result_t     r;
		logic [31:0] rq;
		logic [31:0] sc;
		logic [31:0] q;
		int unsigned k;
		r = '0;
		if (w.opcode) begin
			if (w.query_index >= pairs_used) begin
				r.status = ST_BAD_INDEX;
				return r;
			end
			k = 32'(w.query_index);
			rq = tbl_request[k];
			sc = tbl_success[k];
			if (sc != 0) q = rq / sc;
			else if (rq > scan_threshold) q = rq;
			else q = 32'd1;
			r.status = ST_REPORT;
			r.entry_index = k[9:0];
			r.first_addr = tbl_first[k];
			r.second_addr = tbl_second[k];
			r.connect_requests = rq;
			r.success_responses = sc;
			r.ratio = q;
			r.scan_alert = (q > scan_threshold);
			return r;
		end
		case (w.frame_type)
			EtIpv4: ;
			EtArp: begin r.status = ST_ARP; return r; end
			EtRarp: begin r.status = ST_RARP; return r; end
			EtPup: begin r.status = ST_PUP; return r; end
			default: begin r.status = ST_OTHER; return r; end
		endcase
		if (w.frame_length < MinIpLen) begin
			r.status = ST_SHORT_IP;
			return r;
		end
		if (w.frame_length < MinTcpLen) begin
			r.status = ST_SHORT_TCP;
			return r;
		end
		for (k = 0; k < pairs_used; k++) begin
			if ((tbl_first[k] == w.src_addr && tbl_second[k] == w.dst_addr) ||
			    (tbl_second[k] == w.src_addr && tbl_first[k] == w.dst_addr)) begin
				if ((w.tcp_flags & FlSynAck) == FlSynAck)
					tbl_success[k] = sat_inc(tbl_success[k]);
				else if ((w.tcp_flags & FlSyn) == FlSyn)
					tbl_request[k] = sat_inc(tbl_request[k]);
				r.status = ST_MATCHED;
				r.entry_index = k[9:0];
				r.first_addr = tbl_first[k];
				r.second_addr = tbl_second[k];
				r.connect_requests = tbl_request[k];
				r.success_responses = tbl_success[k];
				return r;
			end
		end
		if (w.tcp_flags != FlSynAck && w.tcp_flags != FlSyn) begin
			r.status = ST_IGNORED;
			return r;
		end
		if (pairs_used >= TableDepth) begin
			r.status = ST_FULL;
			return r;
		end
		k = pairs_used;
		tbl_first[k] = w.src_addr;
		tbl_second[k] = w.dst_addr;
		tbl_request[k] = (w.tcp_flags == FlSyn) ? 32'd1 : 32'd0;
		tbl_success[k] = (w.tcp_flags == FlSynAck) ? 32'd1 : 32'd0;
		pairs_used = k + 1;
		r.status = ST_NEW;
		r.entry_index = k[9:0];
		r.first_addr = w.src_addr;
		r.second_addr = w.dst_addr;
		r.connect_requests = tbl_request[k];
		r.success_responses = tbl_success[k];
		return r;
	endfunction

	// send one word; called just after a rising edge
	task automatic send_word(pkt_word_t w);
		int unsigned gap;
		in_ch.valid <= 1'b1;
		in_ch.opcode <= w.opcode;
		in_ch.frame_type <= w.frame_type;
		in_ch.frame_length <= w.frame_length;
		in_ch.src_addr <= w.src_addr;
		in_ch.dst_addr <= w.dst_addr;
		in_ch.tcp_flags <= w.tcp_flags;
		in_ch.query_index <= w.query_index;
		do @(posedge clk); while (!in_ch.ready);
		pending_results.push_back(predict_result(w));
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_packet(logic [15:0] et, logic [15:0] len, logic [31:0] sa,
			logic [31:0] da, logic [7:0] fl);
		pkt_word_t w;
		w.opcode = 1'b0;
		w.frame_type = et;
		w.frame_length = len;
		w.src_addr = sa;
		w.dst_addr = da;
		w.tcp_flags = fl;
		w.query_index = 10'($urandom_range(0, 1023));
		send_word(w);
	endtask

	// non-index fields carry noise
	task automatic send_query(logic [9:0] idx);
		pkt_word_t w;
		w.opcode = 1'b1;
		w.frame_type = 16'($urandom_range(0, 65535));
		w.frame_length = 16'($urandom_range(0, 65535));
		w.src_addr = $urandom;
		w.dst_addr = $urandom;
		w.tcp_flags = 8'($urandom_range(0, 255));
		w.query_index = idx;
		send_word(w);
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DrainWait) @(posedge clk);
	endtask

	// threshold write, only with nothing in flight
	task automatic write_threshold(logic [15:0] v);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		scan_threshold = v;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("mismatch on %s: got %0h, expected %0h (t=%0t)", field, got, want, $time);
		mismatch_count++;
	endtask

	// result sink: random stalls
	always @(posedge clk) begin
		if (snk_stall_left != 0) begin
			snk_stall_left <= snk_stall_left - 1;
			out_ch.ready <= 1'b0;
		end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
			snk_stall_left <= $urandom_range(0, 16);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", {28'd0, out_ch.status}, 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (out_ch.status !== want.status)
					report_mismatch("status", out_ch.status, want.status);
				if (out_ch.entry_index !== want.entry_index)
					report_mismatch("entry_index", out_ch.entry_index, want.entry_index);
				if (out_ch.first_addr !== want.first_addr)
					report_mismatch("first_addr", out_ch.first_addr, want.first_addr);
				if (out_ch.second_addr !== want.second_addr)
					report_mismatch("second_addr", out_ch.second_addr, want.second_addr);
				if (out_ch.connect_requests !== want.connect_requests)
					report_mismatch("connect_requests", out_ch.connect_requests,
						want.connect_requests);
				if (out_ch.success_responses !== want.success_responses)
					report_mismatch("success_responses", out_ch.success_responses,
						want.success_responses);
				if (out_ch.ratio !== want.ratio)
					report_mismatch("ratio", out_ch.ratio, want.ratio);
				if (out_ch.scan_alert !== want.scan_alert)
					report_mismatch("scan_alert", out_ch.scan_alert, want.scan_alert);
			end
		end
	end

	// classification, short frames, match in both directions, flag handling
	task automatic test_directed();
		int i;
		send_packet(EtArp, 16'd60, 32'd1, 32'd2, FlSyn);
		send_packet(EtRarp, 16'd60, 32'd1, 32'd2, FlSyn);
		send_packet(EtPup, 16'd60, 32'd1, 32'd2, FlSyn);
		send_packet(16'hFFFF, 16'hFFFF, 32'd1, 32'd2, FlSyn);
		send_packet(EtIpv4, 16'd0, 32'd1, 32'd2, FlSyn);
		send_packet(EtIpv4, 16'd33, 32'd1, 32'd2, FlSyn);
		send_packet(EtIpv4, 16'd34, 32'd1, 32'd2, FlSyn);
		send_packet(EtIpv4, 16'd53, 32'd1, 32'd2, FlSyn);
		send_packet(EtIpv4, 16'd54, 32'hFFFF_FFFF, 32'h0, FlSyn);
		send_query(10'd0);
		send_packet(EtIpv4, 16'd60, 32'h0, 32'hFFFF_FFFF, FlSynAck);
		send_packet(EtIpv4, 16'd60, 32'hFFFF_FFFF, 32'h0, 8'hFF);
		send_packet(EtIpv4, 16'd60, 32'h0, 32'hFFFF_FFFF, 8'h00);
		send_packet(EtIpv4, 16'd60, 32'h1234_5678, 32'h9ABC_DEF0, 8'h00);
		send_packet(EtIpv4, 16'd60, 32'h1234_5678, 32'h9ABC_DEF0, 8'h13);
		send_packet(EtIpv4, 16'hFFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A, FlSynAck);
		send_query(10'd1);
		send_query(10'd1023);
		send_query(10'd2);
		send_packet(EtIpv4, 16'd80, 32'hC0A8_0001, 32'hC0A8_0002, FlSyn);
		for (i = 0; i < 5; i++)
			send_packet(EtIpv4, 16'd80, 32'hC0A8_0001, 32'hC0A8_0002, FlSyn);
		send_query(10'd2);
		send_query(10'd0);
	endtask

	// ratio and alert across threshold extremes
	task automatic test_threshold_sweep();
		logic [15:0] settings [4];
		int s;
		int i;
		settings[0] = 16'd0;
		settings[1] = 16'hFFFF;
		settings[2] = 16'($urandom_range(1, 8));
		settings[3] = ThreshReset;
		for (s = 0; s < 4; s++) begin
			write_threshold(settings[s]);
			for (i = 0; i < pairs_used; i++)
				send_query(i[9:0]);
			send_query(pairs_used[9:0]);
		end
	endtask

	// random traffic over a small pool of pairs
	task automatic test_random_traffic(int n_items);
		int i;
		int p;
		int sel;
		logic [7:0]  fl;
		logic [15:0] et;
		logic [15:0] len;
		for (i = 0; i < PoolSize; i++) begin
			pool_a[i] = $urandom;
			pool_b[i] = $urandom;
		end
		for (i = 0; i < n_items; i++) begin
			// idle-free stretches now and then
			src_idle_en = ((i / 60) % 3) != 2;
			snk_idle_en = ((i / 45) % 3) != 1;
			if (i == n_items / 2)
				write_threshold(16'($urandom_range(0, 65535)));
			sel = $urandom_range(0, 99);
			if (sel < 15) begin
				if (pairs_used != 0 && $urandom_range(0, 3) != 0)
					send_query(10'($urandom_range(0, pairs_used - 1)));
				else
					send_query(10'($urandom_range(0, 1023)));
				continue;
			end
			p = $urandom_range(0, PoolSize - 1);
			case ($urandom_range(0, 5))
				0, 1: fl = FlSyn;
				2: fl = FlSynAck;
				3: fl = FlSynAck | 8'($urandom_range(0, 255));
				4: fl = FlSyn | 8'($urandom_range(0, 255));
				default: fl = 8'($urandom_range(0, 255));
			endcase
			et = EtIpv4;
			len = 16'($urandom_range(54, 1518));
			if (sel < 25) begin
				case ($urandom_range(0, 4))
					0: et = EtArp;
					1: et = EtRarp;
					2: et = EtPup;
					default: et = 16'($urandom_range(0, 65535));
				endcase
				len = 16'($urandom_range(0, 65535));
			end else if (sel < 32) begin
				len = 16'($urandom_range(0, 53));
			end else if (sel < 36) begin
				len = 16'($urandom_range(0, 65535));
			end
			if (sel >= 95)
				send_packet(et, len, $urandom, $urandom, fl);
			else if ($urandom_range(0, 1))
				send_packet(et, len, pool_a[p], pool_b[p], fl);
			else
				send_packet(et, len, pool_b[p], pool_a[p], fl);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.opcode = 1'b0;
		in_ch.frame_type = '0;
		in_ch.frame_length = '0;
		in_ch.src_addr = '0;
		in_ch.dst_addr = '0;
		in_ch.tcp_flags = '0;
		in_ch.query_index = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		cycle_count = 0;
		mismatch_count = 0;
		snk_stall_left = 0;
		pairs_used = 0;
		scan_threshold = ThreshReset;
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_threshold_sweep();
		test_random_traffic(250);
		// closing stretch with no idling
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		test_threshold_sweep();

		wait_idle();
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
